/* hw/rtl/running_min_max_blank_tracker_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the running min/max blank tracker
// Concurrent assertion wrappers that compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MIN_MAX_BLANK_TRACKER_DEFINES_SVH
`define RUNNING_MIN_MAX_BLANK_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define RMMB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rmmb assertion failed");
`define RMMB_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rmmb forbidden condition");
`else
`define RMMB_ASSERT(label, clk, rst_n, prop)
`define RMMB_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* hw/rtl/rmmb_pkg.sv */
// ----------------------------------------------------------------------------
// Running min/max blank tracker package
// Shared types, widths and the float ordering key.
// ----------------------------------------------------------------------------
`default_nettype none
package rmmb_pkg;

  localparam int unsigned CountBits = 32;
  localparam logic [31:0] BlankReset = 32'hFFFF_FFFF;

  typedef logic [CountBits-1:0] count_t;

  // Classified item passed from the front to the back.
  typedef struct packed {
    logic [31:0] sample;
    logic [31:0] key;
    logic        blank;
    logic        restart;
    logic [31:0] blank_pattern;
  } item_t;

  typedef struct packed {
    logic [31:0] min_value;
    logic [31:0] max_value;
    logic [31:0] min_position;
    logic [31:0] max_position;
    logic [31:0] blank_total;
    logic [31:0] sample_total;
    logic        extrema_valid;
  } result_t;

  // Monotone unsigned key for IEEE ordering, negative zero folded onto zero.
  function automatic logic [31:0] order_key(input logic [31:0] b);
    logic [31:0] v;
    v = (b == 32'h8000_0000) ? 32'h0 : b;
    return v[31] ? ~v : (v | 32'h8000_0000);
  endfunction

  function automatic count_t sat_inc(input count_t c);
    return (c == '1) ? c : c + count_t'(1);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/rmmb_front.sv */
// ----------------------------------------------------------------------------
// Front stage
// Holds the blank register, classifies samples and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none
module rmmb_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [31:0]   cfg_wdata_i,
  input  wire logic          push_i,
  input  wire logic [31:0]   sample_bits_i,
  input  wire logic          restart_i,
  output rmmb_pkg::item_t    item_o,
  output logic               item_valid_o,
  input  wire logic          item_take_i,
  output logic               full_o
);
  import rmmb_pkg::*;

  logic [31:0] blank_q;
  item_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        do_push, zero_s, zero_b;
  item_t       cls;

  assign full_o       = (cnt_q == 2'd2);
  assign do_push      = push_i && !full_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_q];

  assign zero_s = (sample_bits_i[30:0] == 31'd0);
  assign zero_b = (blank_q[30:0] == 31'd0);

  always_comb begin
    cls.sample        = sample_bits_i;
    cls.key           = order_key(sample_bits_i);
    cls.blank         = (sample_bits_i == blank_q) || (zero_s && zero_b);
    cls.restart       = restart_i;
    cls.blank_pattern = blank_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q <= BlankReset;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      cnt_q   <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        blank_q <= cfg_wdata_i;
      end
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (item_take_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, item_take_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rmmb_back.sv */
// ----------------------------------------------------------------------------
// Back stage
// Updates the running statistics and queues one result per item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "running_min_max_blank_tracker_defines.svh"
module rmmb_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rmmb_pkg::item_t item_i,
  input  wire logic          item_valid_i,
  output logic               item_take_o,
  output rmmb_pkg::result_t  result_o,
  output logic               empty_o,
  input  wire logic          pop_i
);
  import rmmb_pkg::*;

  logic        seen_q, seen_d;
  logic [31:0] min_q, min_d, max_q, max_d;
  count_t      minp_q, minp_d, maxp_q, maxp_d;
  count_t      blanks_q, blanks_d, samples_q, samples_d;
  result_t     mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        do_pop;
  result_t     res;

  assign item_take_o = item_valid_i && (cnt_q != 2'd2);
  assign empty_o     = (cnt_q == 2'd0);
  assign do_pop      = pop_i && !empty_o;
  assign result_o    = mem_q[rd_q];

  always_comb begin
    logic        seen_b;
    logic [31:0] min_b, max_b;
    count_t      minp_b, maxp_b, blanks_b, idx;
    seen_b   = item_i.restart ? 1'b0 : seen_q;
    min_b    = item_i.restart ? BlankReset : min_q;
    max_b    = item_i.restart ? BlankReset : max_q;
    minp_b   = item_i.restart ? '0 : minp_q;
    maxp_b   = item_i.restart ? '0 : maxp_q;
    blanks_b = item_i.restart ? '0 : blanks_q;
    idx      = item_i.restart ? '0 : samples_q;
    seen_d   = seen_b;
    min_d    = min_b;
    max_d    = max_b;
    minp_d   = minp_b;
    maxp_d   = maxp_b;
    blanks_d = blanks_b;
    if (item_i.blank) begin
      blanks_d = sat_inc(blanks_b);
    end else if (!seen_b) begin
      min_d  = item_i.sample;
      max_d  = item_i.sample;
      minp_d = idx;
      maxp_d = idx;
      seen_d = 1'b1;
    end else if (order_key(min_b) > item_i.key) begin
      min_d  = item_i.sample;
      minp_d = idx;
    end else if (order_key(max_b) < item_i.key) begin
      max_d  = item_i.sample;
      maxp_d = idx;
    end
    samples_d = sat_inc(idx);

    res.min_value     = seen_d ? min_d : item_i.blank_pattern;
    res.max_value     = seen_d ? max_d : item_i.blank_pattern;
    res.min_position  = seen_d ? 32'(minp_d) : 32'd0;
    res.max_position  = seen_d ? 32'(maxp_d) : 32'd0;
    res.blank_total   = 32'(blanks_d);
    res.sample_total  = 32'(samples_d);
    res.extrema_valid = seen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= 1'b0;
      min_q     <= BlankReset;
      max_q     <= BlankReset;
      minp_q    <= '0;
      maxp_q    <= '0;
      blanks_q  <= '0;
      samples_q <= '0;
      wr_q      <= 1'b0;
      rd_q      <= 1'b0;
      cnt_q     <= 2'd0;
    end else begin
      if (item_take_o) begin
        seen_q    <= seen_d;
        min_q     <= min_d;
        max_q     <= max_d;
        minp_q    <= minp_d;
        maxp_q    <= maxp_d;
        blanks_q  <= blanks_d;
        samples_q <= samples_d;
        wr_q      <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, item_take_o} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      mem_q[wr_q] <= res;
    end
  end

  `RMMB_NEVER(a_queue_bound, clk_i, rst_ni, cnt_q == 2'd3)
  `RMMB_ASSERT(a_restart_blank_clears, clk_i, rst_ni,
    (item_take_o && item_i.restart && item_i.blank) |=> !seen_q)
  `RMMB_ASSERT(a_value_sets_seen, clk_i, rst_ni,
    (item_take_o && !item_i.blank) |=> seen_q)
  `RMMB_ASSERT(a_samples_grow, clk_i, rst_ni,
    (item_take_o && !item_i.restart) |=> (samples_q >= $past(samples_q)))

endmodule
`default_nettype wire

/* hw/rtl/running_min_max_blank_tracker.sv */
// A pushed sample waits in the front queue; its result then waits in the back queue.
// Throughput: one sample per cycle while results are popped without a gap; the back
// stage's update of the running state is the loop that sets this rate.
// Reset (rst_ni low, asynchronous) empties both queues, clears the statistics
// and sets the blank pattern to all ones.
// ----------------------------------------------------------------------------
// Running min/max blank tracker
// Running float extrema with positions, skipping and counting blank samples.
// ----------------------------------------------------------------------------
`default_nettype none
module running_min_max_blank_tracker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] sample_bits_i,
  input  wire logic        restart_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      min_value_o,
  output logic [31:0]      max_value_o,
  output logic [31:0]      min_position_o,
  output logic [31:0]      max_position_o,
  output logic [31:0]      blank_total_o,
  output logic [31:0]      sample_total_o,
  output logic             extrema_valid_o
);
  import rmmb_pkg::*;

  item_t   item;
  logic    item_valid, item_take;
  result_t res;

  rmmb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push_i        (push),
    .sample_bits_i (sample_bits_i),
    .restart_i     (restart_i),
    .item_o        (item),
    .item_valid_o  (item_valid),
    .item_take_i   (item_take),
    .full_o        (full)
  );

  rmmb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .result_o     (res),
    .empty_o      (empty),
    .pop_i        (pop)
  );

  assign min_value_o     = res.min_value;
  assign max_value_o     = res.max_value;
  assign min_position_o  = res.min_position;
  assign max_position_o  = res.max_position;
  assign blank_total_o   = res.blank_total;
  assign sample_total_o  = res.sample_total;
  assign extrema_valid_o = res.extrema_valid;

endmodule
`default_nettype wire

/* bench/running_min_max_blank_tracker_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running min/max blank tracker checker
// Watches the sample and result queues, keeps its own copy of the running
// statistics, and compares every popped result with the expected one.
// ----------------------------------------------------------------------------
module running_min_max_blank_tracker_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 push,
  input  logic                 full,
  input  logic [31:0]          sample_bits_i,
  input  logic                 restart_i,
  input  logic                 empty,
  input  logic                 pop,
  input  rmmb_pkg::result_t    result_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  import rmmb_pkg::*;

  logic [31:0] blank_q;
  logic        seen_q;
  logic [31:0] lo_q, hi_q;
  count_t      lo_pos_q, hi_pos_q, blanks_q, samples_q;
  result_t     stats_q[$];

  assign pending_o = stats_q.size();

  function automatic logic [31:0] float_rank(input logic [31:0] b);
    logic [31:0] v;
    v = (b == 32'h8000_0000) ? 32'h0 : b;
    return v[31] ? ~v : {1'b1, v[30:0]};
  endfunction

  function automatic bit matches_blank(input logic [31:0] s, input logic [31:0] bl);
    return (s == bl) || (s[30:0] == 31'h0 && bl[30:0] == 31'h0);
  endfunction

  function automatic count_t bump(input count_t c);
    return (&c) ? c : c + count_t'(1);
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %h actual %h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t r;
    result_t e;
    count_t  idx;
    if (!rst_ni) begin
      blank_q   <= BlankReset;
      seen_q    <= 1'b0;
      lo_q      <= 32'hFFFF_FFFF;
      hi_q      <= 32'hFFFF_FFFF;
      lo_pos_q  <= '0;
      hi_pos_q  <= '0;
      blanks_q  <= '0;
      samples_q <= '0;
      stats_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) blank_q <= cfg_wdata_i;
      if (push && !full) begin
        logic        s_seen;
        logic [31:0] s_lo, s_hi;
        count_t      s_lp, s_hp, s_bl, s_sm;
        s_seen = seen_q; s_lo = lo_q; s_hi = hi_q;
        s_lp = lo_pos_q; s_hp = hi_pos_q; s_bl = blanks_q; s_sm = samples_q;
        if (restart_i) begin
          s_seen = 1'b0; s_lo = '1; s_hi = '1;
          s_lp = '0; s_hp = '0; s_bl = '0; s_sm = '0;
        end
        idx = s_sm;
        if (matches_blank(sample_bits_i, blank_q)) begin
          s_bl = bump(s_bl);
        end else if (!s_seen) begin
          s_lo = sample_bits_i; s_hi = sample_bits_i;
          s_lp = idx; s_hp = idx; s_seen = 1'b1;
        end else if (float_rank(s_lo) > float_rank(sample_bits_i)) begin
          s_lo = sample_bits_i; s_lp = idx;
        end else if (float_rank(s_hi) < float_rank(sample_bits_i)) begin
          s_hi = sample_bits_i; s_hp = idx;
        end
        s_sm = bump(s_sm);
        r.min_value     = s_seen ? s_lo : blank_q;
        r.max_value     = s_seen ? s_hi : blank_q;
        r.min_position  = s_seen ? s_lp[31:0] : 32'h0;
        r.max_position  = s_seen ? s_hp[31:0] : 32'h0;
        r.blank_total   = s_bl[31:0];
        r.sample_total  = s_sm[31:0];
        r.extrema_valid = s_seen;
        stats_q.push_back(r);
        seen_q <= s_seen; lo_q <= s_lo; hi_q <= s_hi;
        lo_pos_q <= s_lp; hi_pos_q <= s_hp; blanks_q <= s_bl; samples_q <= s_sm;
      end
      if (pop && !empty) begin
        if (stats_q.size() == 0) begin
          $error("result popped with no item outstanding");
          fail_count_o++;
        end else begin
          e = stats_q.pop_front();
          check_field("min_value", e.min_value, result_i.min_value);
          check_field("max_value", e.max_value, result_i.max_value);
          check_field("min_position", e.min_position, result_i.min_position);
          check_field("max_position", e.max_position, result_i.max_position);
          check_field("blank_total", e.blank_total, result_i.blank_total);
          check_field("sample_total", e.sample_total, result_i.sample_total);
          check_field("extrema_valid", 32'(e.extrema_valid),
                      32'(result_i.extrema_valid));
        end
      end
    end
  end
endmodule

/* bench/running_min_max_blank_tracker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running min/max blank tracker testbench
// Drives directed and random sample runs under several blank patterns with
// random gaps on both queues; a checker module predicts and compares.
// ----------------------------------------------------------------------------
module running_min_max_blank_tracker_tb;
  import rmmb_pkg::*;

  localparam int IdleLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        push = 1'b0;
  logic [31:0] sample_bits_i = '0;
  logic        restart_i = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty;
  result_t     result;
  int          fail_count, pending;
  logic [31:0] blank_now = BlankReset;
  int          idle_cycles = 0;

  running_min_max_blank_tracker uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .push, .full, .sample_bits_i,
    .restart_i, .empty, .pop,
    .min_value_o(result.min_value), .max_value_o(result.max_value),
    .min_position_o(result.min_position), .max_position_o(result.max_position),
    .blank_total_o(result.blank_total), .sample_total_o(result.sample_total),
    .extrema_valid_o(result.extrema_valid)
  );

  running_min_max_blank_tracker_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .push, .full, .sample_bits_i,
    .restart_i, .empty, .pop, .result_i(result),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Result side: random pop gaps, with long stretches of steady popping.
  // Pop is only lowered when a gap follows, so back-to-back pops keep it high.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("FAIL running_min_max_blank_tracker");
      $finish;
    end
  end

  // Push stays high after an accepted item; the next gap or the caller lowers it.
  task automatic send(input logic [31:0] s, input logic rs, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    sample_bits_i <= s;
    restart_i <= rs;
    do @(posedge clk_i); while (full);
  endtask

  task automatic set_blank(input logic [31:0] b);
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    blank_now = b;
  endtask

  // Ordinary floats half the time, with zeros, infinities, the blank, its neighbour and raw bits.
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return blank_now;
      1: return {$urandom_range(0, 1) == 1, 31'h0};
      2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'h0};
      3: return $urandom();
      4: return {blank_now[31:1], ~blank_now[0]};
      default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(120, 135)),
                       23'($urandom())};
    endcase
  endfunction

  initial begin
    logic [31:0] blanks[6];
    blanks = '{32'h0000_0000, 32'h7FC0_0000, 32'h3F80_0000, 32'h8000_0000,
               32'h0000_0000, 32'hFFFF_FFFF};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: blanks before any value, extremes, ties, signed zeros.
    send(32'hFFFF_FFFF, 1'b0, 1'b0);
    send(32'hFFFF_FFFF, 1'b0, 1'b1);
    send(32'h3F80_0000, 1'b0, 1'b1);
    send(32'h3F80_0000, 1'b0, 1'b0);
    send(32'h0000_0000, 1'b0, 1'b1);
    send(32'h8000_0000, 1'b0, 1'b1);
    send(32'h7F80_0000, 1'b0, 1'b0);
    send(32'hFF80_0000, 1'b0, 1'b1);
    send(32'h7F7F_FFFF, 1'b0, 1'b1);
    send(32'h0000_0001, 1'b1, 1'b0);
    send(32'h8000_0001, 1'b0, 1'b1);
    send(32'hFFFF_FFFF, 1'b1, 1'b1);
    send(32'h0000_0000, 1'b0, 1'b1);
    set_blank(32'h0000_0000);
    send(32'h8000_0000, 1'b1, 1'b0);
    send(32'h0000_0000, 1'b0, 1'b1);
    send(32'hBF80_0000, 1'b0, 1'b1);
    set_blank(32'h4000_0000);
    send(32'h4000_0000, 1'b0, 1'b0);
    send(32'hC000_0000, 1'b0, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      set_blank(ph == 4 ? $urandom() : blanks[ph]);
      for (int i = 0; i < 65; i++) begin
        send(pick_sample(), $urandom_range(0, 19) == 0, $urandom_range(0, 3) == 0);
      end
    end

    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS running_min_max_blank_tracker");
    end else begin
      $display("FAIL running_min_max_blank_tracker");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/rmmb_pkg.sv
hw/rtl/rmmb_front.sv
hw/rtl/rmmb_back.sv
hw/rtl/running_min_max_blank_tracker.sv
bench/running_min_max_blank_tracker_checker.sv
bench/running_min_max_blank_tracker_tb.sv
